// File: hw/rtl/ees_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Experience exchange sorter package
// Shared sizes, payload types, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ees_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam int YEAR_W = 12;
  localparam int KEY_W  = 13;
  localparam int ID_W   = 16;

  localparam logic [YEAR_W-1:0] YEAR_RESET = YEAR_W'(2000);

  typedef struct packed {
    logic [YEAR_W-1:0] hire_year;
    logic [ID_W-1:0]   record_id;
    logic              last_record;
  } ees_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] experience;
    logic [ID_W-1:0]         sorted_id;
    logic                    last_out;
    logic                    overflow;
  } ees_out_t;

  // One stored record: experience key and id.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         id;
  } ees_entry_t;

  typedef enum logic [2:0] {
    S_FILL,
    S_RDROW,
    S_LDROW,
    S_CMP,
    S_WRROW,
    S_ERD,
    S_EOUT
  } ees_state_t;

  typedef struct packed {
    logic store;    // take one record into the store
    logic rd_row;   // read the entry of the current row
    logic ld_row;   // hold the row entry, read the first later entry
    logic cmp;      // compare the held entry with one later entry
    logic wr_row;   // write the held entry back to its row
    logic emit_rd;  // read the first entry for output
    logic emit_ld;  // move one entry into the output register
    logic clear;    // start a new set
  } ees_cmd_t;

  typedef struct packed {
    logic empty;      // nothing stored yet
    logic cmp_last;   // the compare is at the last stored entry
    logic row_more;   // another row remains after this one
    logic emit_last;  // the entry being sent is the last one
    logic out_free;   // the output register can take an entry
  } ees_status_t;

endpackage

// File: hw/rtl/ees_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Experience exchange sorter controller
// Sequences filling, the exchange sort passes and emission of the results.
// ----------------------------------------------------------------------------
module ees_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  input  ees_pkg::ees_status_t status,
  output logic                 in_ready,
  output ees_pkg::ees_cmd_t    cmd
);
  import ees_pkg::*;

  ees_state_t state;
  ees_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            // A single record needs no sorting.
            state_next = status.empty ? S_ERD : S_RDROW;
          end
        end
      end
      S_RDROW: begin
        cmd.rd_row = 1'b1;
        state_next = S_LDROW;
      end
      S_LDROW: begin
        cmd.ld_row = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (status.cmp_last) begin
          state_next = S_WRROW;
        end
      end
      S_WRROW: begin
        cmd.wr_row = 1'b1;
        state_next = status.row_more ? S_LDROW : S_ERD;
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EOUT;
      end
      S_EOUT: begin
        if (status.out_free) begin
          cmd.emit_ld = 1'b1;
          if (status.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = S_FILL;
          end
        end
      end
      default: begin
        state_next = S_FILL;
      end
    endcase
  end

endmodule

// File: hw/rtl/ees_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Experience exchange sorter datapath
// Record store, held row entry, current year register, sort counters and the output register.
// ----------------------------------------------------------------------------
module ees_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [ees_pkg::YEAR_W-1:0]    cfg_data,
  input  ees_pkg::ees_in_t              in_data,
  input  ees_pkg::ees_cmd_t             cmd,
  output ees_pkg::ees_status_t          status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output ees_pkg::ees_out_t             out_data
);
  import ees_pkg::*;

  logic [YEAR_W-1:0] current_year;
  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  emit_idx;
  ees_entry_t        cur;
  ees_entry_t        rd_entry;
  ees_entry_t        mem [MAX_RECORDS];

  logic              full;
  logic              swap;
  ees_entry_t        new_entry;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  ees_entry_t        wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  assign full          = (count == CNT_W'(MAX_RECORDS));
  assign swap          = ($signed(cur.key) > $signed(rd_entry.key));
  assign new_entry.key = $signed(KEY_W'({1'b0, current_year}) - KEY_W'({1'b0, in_data.hire_year}));
  assign new_entry.id  = in_data.record_id;

  assign status.empty     = (count == '0);
  assign status.cmp_last  = (CNT_W'(col) == count - CNT_W'(1));
  assign status.row_more  = (SUM_W'(row) + SUM_W'(2) < SUM_W'(count));
  assign status.emit_last = (CNT_W'(emit_idx) == count - CNT_W'(1));
  assign status.out_free  = !out_valid || out_ready;

  // Store port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = cur;
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.store && !full) begin
      wr_en   = 1'b1;
      wr_addr = count[IDX_W-1:0];
      wr_data = new_entry;
    end
    if (cmd.cmp && swap) begin
      wr_en   = 1'b1;
      wr_addr = col;
    end
    if (cmd.wr_row) begin
      wr_en   = 1'b1;
      wr_addr = row;
    end
    if (cmd.rd_row) begin
      rd_en   = 1'b1;
      rd_addr = row;
    end
    if (cmd.ld_row || cmd.wr_row) begin
      rd_en   = 1'b1;
      rd_addr = row + IDX_W'(1);
    end
    if (cmd.cmp && !status.cmp_last) begin
      rd_en   = 1'b1;
      rd_addr = col + IDX_W'(1);
    end
    if (cmd.emit_rd) begin
      rd_en   = 1'b1;
      rd_addr = emit_idx;
    end
    if (cmd.emit_ld && !status.emit_last) begin
      rd_en   = 1'b1;
      rd_addr = emit_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  // The held entry keeps the running minimum of the current row.
  always_ff @(posedge clk) begin
    if (cmd.ld_row || (cmd.cmp && swap)) begin
      cur <= rd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_year <= YEAR_RESET;
    end else if (cfg_valid) begin
      current_year <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf      <= 1'b0;
      row      <= '0;
      col      <= '0;
      emit_idx <= '0;
    end else if (cmd.clear) begin
      count    <= '0;
      ovf      <= 1'b0;
      row      <= '0;
      col      <= '0;
      emit_idx <= '0;
    end else begin
      if (cmd.store) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.ld_row) begin
        col <= row + IDX_W'(1);
      end
      if (cmd.cmp && !status.cmp_last) begin
        col <= col + IDX_W'(1);
      end
      if (cmd.wr_row) begin
        row <= row + IDX_W'(1);
      end
      if (cmd.emit_ld) begin
        emit_idx <= emit_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_data.experience <= rd_entry.key;
      out_data.sorted_id  <= rd_entry.id;
      out_data.last_out   <= status.emit_last;
      out_data.overflow   <= ovf;
    end
  end

endmodule

// File: hw/rtl/experience_exchange_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Experience exchange sorter
// Collects a set of records, sorts them by experience with an exchange sort
// and sends them out in ascending order.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while it is filling: each carries a
// hire year, a record id and a last-record flag, and the experience key
// (current year minus hire year, 13-bit two's complement) is stored with the
// id in a 16-entry store with one read and one write port. Records past the
// sixteenth are dropped and mark every result of that set with the overflow
// flag. After the last record the block stops taking requests and sorts: for
// each row i the entry at i is held in a register and compared against every
// later entry, one per cycle, swapping on a strictly greater key, so equal
// keys keep exactly the order of a classic exchange sort. For two or more
// stored records the sort does one compare per cycle through the store's
// single read port; a single record skips the sort. Emission reads the
// first entry, then moves each result into the output register whenever
// it has room, so a stalling consumer holds emission up. The last result
// carries last_out, and the block accepts the next set while that result
// still waits in the output register. The current year register resets to
// 2000 and is written through the cfg channel, which is always ready; write
// it only between sets.
// ----------------------------------------------------------------------------
module experience_exchange_sorter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ees_pkg::YEAR_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ees_pkg::ees_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ees_pkg::ees_out_t          out_data
);
  import ees_pkg::*;

  ees_cmd_t    cmd;
  ees_status_t status;

  // The year register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // The controller walks the fill, sort and emit phases and issues one
  // command group per cycle.
  ees_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_record),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // The datapath holds the store, the sort counters and the output register.
  ees_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Once the last record of a set is taken, in_ready drops; no request is taken
  // until the last result of the set has been loaded into the output register.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last_record |=> !in_ready)
    else $error("request taken right after the last record of a set");

  // Once the last result of a set is loaded into the output register, the
  // block is filling again in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit_ld && status.emit_last |=> in_ready)
    else $error("block not filling after the last result was loaded");

  // The controller issues at most one datapath operation per cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.store, cmd.rd_row, cmd.ld_row, cmd.cmp, cmd.wr_row,
              cmd.emit_rd, cmd.emit_ld}))
    else $error("more than one datapath operation in a cycle");

  // A result is moved into the output register only when it has room.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit_ld |-> status.out_free)
    else $error("output register overwritten while still full");

endmodule
